[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; users supply clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define BCDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising edge, reset included
`define BCDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bcdc_pkg.sv]
// types and constants of the brake chopper duty control
// no dependencies
`default_nettype none
package bcdc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ON_LEVEL    = 3'd0;
  localparam logic [2:0] REG_OFF_LEVEL   = 3'd1;
  localparam logic [2:0] REG_DUTY_GAIN   = 3'd2;
  localparam logic [2:0] REG_MAX_DUTY    = 3'd3;
  localparam logic [2:0] REG_HALF_PERIOD = 3'd4;
  localparam logic [2:0] REG_DEAD_TICKS  = 3'd5;

  localparam logic [16:0] HALF_PERIOD_RESET = 17'd1;
  localparam logic [15:0] DEAD_TICKS_RESET  = 16'd1;
  // unity duty in q0.16
  localparam logic [16:0] DUTY_ONE = 17'h10000;

  typedef struct packed {
    logic [14:0] on_level;
    logic [14:0] off_level;
    logic [15:0] duty_gain;
    logic [15:0] max_duty;
    logic [16:0] half_period;
    logic [15:0] dead_ticks;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic        off;
    logic        engaged;
    logic [14:0] delta;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

[rtl/bcdc_queue.sv]
// two-entry queue of classified samples between front and back
// depends on bcdc_pkg
`default_nettype none
module bcdc_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  bcdc_pkg::job_t  push_job,
  input  wire             pop,
  output bcdc_pkg::job_t  pop_job,
  output bcdc_pkg::q_status_t status
);
  import bcdc_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  assign pop_job      = slots[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
endmodule
`default_nettype wire

[rtl/bcdc_front.sv]
// front part: takes samples, runs the hysteresis flag, classifies each sample
// depends on bcdc_pkg; feeds bcdc_queue
`default_nettype none
module bcdc_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire signed [15:0]      bus_voltage,
  input  wire                    stage_armed,
  input  bcdc_pkg::cfg_t         cfg,
  input  bcdc_pkg::q_status_t    q_status,
  output logic                   push,
  output bcdc_pkg::job_t         push_job,
  output logic                   engaged
);
  import bcdc_pkg::*;

  logic        engaged_next;
  logic        positive;
  logic [14:0] v_mag;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;
  assign positive = !bus_voltage[15] && (bus_voltage[14:0] != 15'd0);
  assign v_mag    = bus_voltage[14:0];

  always_comb begin
    engaged_next   = engaged;
    push_job.off   = 1'b1;
    push_job.delta = 15'd0;
    if (!stage_armed || !positive) begin
      engaged_next = 1'b0;
    end else if (!engaged && v_mag <= cfg.on_level) begin
      engaged_next = 1'b0;
    end else if (engaged && v_mag < cfg.off_level) begin
      engaged_next = 1'b0;
    end else begin
      engaged_next = 1'b1;
      push_job.off = 1'b0;
      // at or below the off level the duty origin gives zero
      if (v_mag > cfg.off_level) push_job.delta = v_mag - cfg.off_level;
    end
    push_job.engaged = engaged_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      engaged <= 1'b0;
    end else if (push) begin
      engaged <= engaged_next;
    end
  end
endmodule
`default_nettype wire

[rtl/bcdc_back.sv]
// back part: duty scaling and compare values through one shared multiplier
// depends on bcdc_pkg; drains bcdc_queue, drives the result registers
`default_nettype none
module bcdc_back (
  input  wire                  clk,
  input  wire                  rst,
  input  bcdc_pkg::cfg_t       cfg,
  input  bcdc_pkg::q_status_t  q_status,
  input  bcdc_pkg::job_t       pop_job,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [16:0]          low_compare,
  output logic [16:0]          high_compare,
  output logic [15:0]          duty_now,
  output logic                 is_engaged
);
  import bcdc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_SHIP = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  job_t        job;
  logic [33:0] prod;
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [15:0] duty;
  logic [15:0] duty_sat;
  logic [16:0] mid;
  logic [16:0] lo;
  logic        ship;
  logic        ship_off;

  // saturate the scaled product, bits 23 down to 8 are the q0.16 duty
  always_comb begin
    if (prod[33:8] > {10'd0, cfg.max_duty}) duty_sat = cfg.max_duty;
    else                                   duty_sat = prod[23:8];
  end

  always_comb begin
    if (state == S_MUL1) begin
      mul_a = {2'd0, job.delta};
      mul_b = {1'b0, cfg.duty_gain};
    end else begin
      mul_a = cfg.half_period;
      mul_b = DUTY_ONE - {1'b0, duty_sat};
    end
  end

  assign mid      = prod[32:16];
  assign lo       = (mid > {1'b0, cfg.dead_ticks}) ? mid - {1'b0, cfg.dead_ticks} : 17'd0;
  assign ship     = (state == S_SHIP) && (!out_valid || !out_stall);
  assign ship_off = job.off || (duty == 16'd0);
  assign pop      = (state == S_IDLE) && !q_status.empty;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (pop) state_next = pop_job.off ? S_SHIP : S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_SHIP;
      S_SHIP: if (ship) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ship)           out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job <= pop_job;
    if (state == S_MUL1 || state == S_MUL2) prod <= mul_a * mul_b;
    if (state == S_MUL2) duty <= duty_sat;
    if (ship) begin
      is_engaged <= job.engaged;
      if (ship_off) begin
        low_compare  <= 17'd0;
        high_compare <= cfg.half_period;
        duty_now     <= 16'd0;
      end else begin
        low_compare  <= lo;
        high_compare <= mid;
        duty_now     <= duty;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/brake_chopper_duty_control.sv]
// Brake chopper duty control. Each transfer on the input carries one bus
// voltage sample (signed q8.8 volts) and the stage armed flag; each yields
// exactly one result transfer with the low and high compare values for a
// centre-aligned timer, the applied q0.16 duty and the engaged flag. The
// front takes a sample, updates the hysteresis flag and queues a short job
// in the same cycle, stalling while the queue is full; the back drains the
// queue with a single 17x17 multiplier, used twice by an engaged sample
// that runs idle, mul1, mul2, ship to the result register; an off sample
// runs idle, ship. The back pops no job until the current one ships; a
// two-entry queue and the result register let the sample side run ahead
// while a result waits. Registers sit on an apb-style port at byte
// addresses 4*i and should be written while no sample is in flight.
// depends on bcdc_pkg, bcdc_front, bcdc_queue, bcdc_back, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module brake_chopper_duty_control (
  input  wire               clk,
  input  wire               rst,
  // apb-style configuration port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [4:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // sample channel
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] bus_voltage,
  input  wire               stage_armed,
  // result channel
  output logic              out_valid,
  input  wire               out_stall,
  output logic [16:0]       low_compare,
  output logic [16:0]       high_compare,
  output logic [15:0]       duty_now,
  output logic              is_engaged
);
  import bcdc_pkg::*;

  cfg_t      cfg;
  q_status_t q_status;
  job_t      push_job;
  job_t      pop_job;
  logic      push;
  logic      pop;
  logic      engaged;
  logic      cfg_write;
  logic [2:0] reg_index;

  // configuration registers, written on the access phase of a write transfer
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_level    <= 15'd0;
      cfg.off_level   <= 15'd0;
      cfg.duty_gain   <= 16'd0;
      cfg.max_duty    <= 16'd0;
      cfg.half_period <= HALF_PERIOD_RESET;
      cfg.dead_ticks  <= DEAD_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ON_LEVEL:    cfg.on_level    <= pwdata[14:0];
        REG_OFF_LEVEL:   cfg.off_level   <= pwdata[14:0];
        REG_DUTY_GAIN:   cfg.duty_gain   <= pwdata[15:0];
        REG_MAX_DUTY:    cfg.max_duty    <= pwdata[15:0];
        REG_HALF_PERIOD: cfg.half_period <= pwdata[16:0];
        REG_DEAD_TICKS:  cfg.dead_ticks  <= pwdata[15:0];
        default: ;  // addresses past the last register are ignored
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_index)
      REG_ON_LEVEL:    prdata = {17'd0, cfg.on_level};
      REG_OFF_LEVEL:   prdata = {17'd0, cfg.off_level};
      REG_DUTY_GAIN:   prdata = {16'd0, cfg.duty_gain};
      REG_MAX_DUTY:    prdata = {16'd0, cfg.max_duty};
      REG_HALF_PERIOD: prdata = {15'd0, cfg.half_period};
      REG_DEAD_TICKS:  prdata = {16'd0, cfg.dead_ticks};
      default:         prdata = 32'd0;
    endcase
  end

  // front: hysteresis and classification, one sample per cycle while the queue is not full
  bcdc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .bus_voltage (bus_voltage),
    .stage_armed (stage_armed),
    .cfg         (cfg),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job),
    .engaged     (engaged)
  );

  // decoupling queue between the two halves
  bcdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // back: duty scaling, saturation and compare values
  bcdc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_status     (q_status),
    .pop_job      (pop_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .low_compare  (low_compare),
    .high_compare (high_compare),
    .duty_now     (duty_now),
    .is_engaged   (is_engaged)
  );

  // checks on the block's own logic
  `BCDC_ASSERT(a_disarm_releases, (push && !stage_armed) |=> !engaged, "flag kept after disarm")
  `BCDC_ASSERT(a_compare_order, out_valid |-> low_compare <= high_compare, "compares out of order")
  `BCDC_ASSERT(a_duty_needs_engaged, (out_valid && |duty_now) |-> is_engaged, "duty when released")
  `BCDC_ASSERT(a_queue_no_overflow, q_status.full |-> !push, "push into full queue")
endmodule
`default_nettype wire
